/* rtl/esbrb_pkg.sv */
package esbrb_pkg;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int PRESCALE_W  = 11;
    localparam int PCOUNT_W    = 10;
    localparam int BIT_IDX_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0]     INITIAL_RELOAD_RST = 8'h6A;
    localparam logic [BYTE_W-1:0]     SAMPLE_START_RST   = 8'd224;
    localparam logic [PRESCALE_W-1:0] PRESCALE_DIV_RST   = 11'd256;
    localparam logic [BYTE_W-1:0]     HOLD_OVERFLOWS_RST = 8'h07;

    // prescaler limits
    localparam logic [PRESCALE_W-1:0] PRESCALE_MIN = 11'd1;
    localparam logic [PRESCALE_W-1:0] PRESCALE_MAX = 11'd1024;

    localparam logic [BYTE_W-1:0]    COUNT_TOP     = 8'hFF;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX  = 4'd7;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_RELOAD = 2'd0,
        CFG_SAMPLE_START   = 2'd1,
        CFG_PRESCALE_DIV   = 2'd2,
        CFG_HOLD_OVERFLOWS = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0]     sample_start;
        logic [PRESCALE_W-1:0] prescale_div;
        logic [BYTE_W-1:0]     hold_overflows;
    } cfg_t;

    typedef struct packed {
        logic              reading;
        logic [BYTE_W-1:0] byte_value;
        logic              byte_valid;
        logic              received_led;
        logic              blink_led;
    } result_t;

endpackage

/* rtl/esbrb_core.sv */
module esbrb_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  esbrb_pkg::cfg_t        cfg,
    input  logic                   in_fire,
    input  logic                   bus,
    output esbrb_pkg::result_t     res
);

    logic                                read_mode_reg, read_mode_next;
    logic [esbrb_pkg::BIT_IDX_W-1:0]     bit_index_reg, bit_index_next;
    logic [esbrb_pkg::BYTE_W-1:0]        shift_byte_reg, shift_byte_next;
    logic [esbrb_pkg::BYTE_W-1:0]        period_reg, period_next;
    logic [esbrb_pkg::PCOUNT_W-1:0]      pcount_reg, pcount_next;
    logic [esbrb_pkg::BYTE_W-1:0]        step_reg, step_next;
    logic                                enabled_reg, enabled_next;
    logic                                blink_reg, blink_next;
    logic                                recv_reg, recv_next;
    logic [esbrb_pkg::BYTE_W-1:0]        hold_reg, hold_next;
    logic                                last_bus_reg, last_bus_next;

    logic [esbrb_pkg::PRESCALE_W-1:0]    div_eff;
    logic [esbrb_pkg::PRESCALE_W-1:0]    pcount_inc;
    logic                                step;
    logic                                done;
    logic [esbrb_pkg::BYTE_W-1:0]        done_value;

    // clamp the prescaler divisor
    always_comb
    begin
        if (cfg.prescale_div < esbrb_pkg::PRESCALE_MIN)
        begin
            div_eff = esbrb_pkg::PRESCALE_MIN;
        end
        else if (cfg.prescale_div > esbrb_pkg::PRESCALE_MAX)
        begin
            div_eff = esbrb_pkg::PRESCALE_MAX;
        end
        else
        begin
            div_eff = cfg.prescale_div;
        end
    end

    assign pcount_inc = {1'b0, pcount_reg} + 1'b1;

    // one tick: counter step, falling edge, byte completion, hold check
    always_comb
    begin
        read_mode_next  = read_mode_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        period_next     = period_reg;
        pcount_next     = pcount_reg;
        step_next       = step_reg;
        enabled_next    = enabled_reg;
        blink_next      = blink_reg;
        recv_next       = recv_reg;
        hold_next       = hold_reg;
        last_bus_next   = bus;
        step            = 1'b0;
        done            = 1'b0;
        done_value      = '0;

        // prescaler, bypassed in read mode
        if (read_mode_reg)
        begin
            step = 1'b1;
        end
        else if (pcount_inc >= div_eff)
        begin
            pcount_next = '0;
            step        = 1'b1;
        end
        else
        begin
            pcount_next = pcount_inc[esbrb_pkg::PCOUNT_W-1:0];
        end

        // counter step and overflow action
        if (step)
        begin
            if (step_reg == esbrb_pkg::COUNT_TOP)
            begin
                step_next = '0;
                if (enabled_reg)
                begin
                    if (read_mode_reg)
                    begin
                        enabled_next = 1'b0;
                        if (bus)
                        begin
                            shift_byte_next[bit_index_reg[2:0]] = 1'b1;
                        end
                        bit_index_next = bit_index_reg + 1'b1;
                    end
                    else
                    begin
                        blink_next = ~blink_reg;
                        step_next  = period_reg;
                        if (recv_reg)
                        begin
                            hold_next = hold_reg + 1'b1;
                        end
                    end
                end
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end

        // falling edge arms a sample
        if (last_bus_reg && !bus)
        begin
            if (!read_mode_reg)
            begin
                blink_next     = 1'b0;
                recv_next      = 1'b0;
                read_mode_next = 1'b1;
                pcount_next    = '0;
            end
            step_next    = cfg.sample_start;
            enabled_next = 1'b1;
        end

        // byte complete: new period, back to blinking
        if (bit_index_next > esbrb_pkg::LAST_BIT_IDX)
        begin
            done            = 1'b1;
            done_value      = shift_byte_next;
            recv_next       = 1'b1;
            period_next     = shift_byte_next;
            shift_byte_next = '0;
            bit_index_next  = '0;
            if (read_mode_next)
            begin
                pcount_next = '0;
            end
            read_mode_next  = 1'b0;
            step_next       = done_value;
            enabled_next    = 1'b1;
        end

        // received led hold expiry
        if (hold_next >= cfg.hold_overflows)
        begin
            recv_next = 1'b0;
            hold_next = '0;
        end
    end

    // result of this tick
    always_comb
    begin
        res.blink_led    = blink_next;
        res.received_led = recv_next;
        res.byte_valid   = done;
        res.byte_value   = done_value;
        res.reading      = read_mode_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_mode_reg  <= 1'b0;
            bit_index_reg  <= '0;
            shift_byte_reg <= '0;
            period_reg     <= esbrb_pkg::INITIAL_RELOAD_RST;
            pcount_reg     <= '0;
            step_reg       <= esbrb_pkg::INITIAL_RELOAD_RST;
            enabled_reg    <= 1'b1;
            blink_reg      <= 1'b0;
            recv_reg       <= 1'b0;
            hold_reg       <= '0;
            last_bus_reg   <= 1'b1;
        end
        else if (in_fire)
        begin
            read_mode_reg  <= read_mode_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
            period_reg     <= period_next;
            pcount_reg     <= pcount_next;
            step_reg       <= step_next;
            enabled_reg    <= enabled_next;
            blink_reg      <= blink_next;
            recv_reg       <= recv_next;
            hold_reg       <= hold_next;
            last_bus_reg   <= last_bus_next;
        end
    end

endmodule

/* rtl/edge_sampled_byte_receiver_blinker_unit.sv */
// each result is registered in a two-entry output buffer; the block takes one
// request per cycle while s_tready is high, and the buffer keeps taking
// requests while the result side stalls, until both of its entries are full
// reset: rst_n is asynchronous, active low; it resets the receiver state, returns the
// configuration registers to their defaults and empties the output buffer
module edge_sampled_byte_receiver_blinker_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [esbrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [esbrb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [esbrb_pkg::IN_TDATA_W-1:0]     s_tdata,  // [0] bus_level
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] blink_led, [1] received_led, [2] byte_valid, [10:3] byte_value,
    // [11] reading, [15:12] zero
    output logic [esbrb_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    esbrb_pkg::cfg_t    cfg_reg;
    esbrb_pkg::result_t res;
    esbrb_pkg::result_t out_reg;
    esbrb_pkg::result_t skid_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               in_fire;
    logic               out_free;

    // configuration writes; the reload register only matters at reset,
    // where it holds its default, so a write to it has no effect
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_start   <= esbrb_pkg::SAMPLE_START_RST;
            cfg_reg.prescale_div   <= esbrb_pkg::PRESCALE_DIV_RST;
            cfg_reg.hold_overflows <= esbrb_pkg::HOLD_OVERFLOWS_RST;
        end
        else if (cfg_we)
        begin
            case (esbrb_pkg::cfg_index_t'(cfg_index))
                esbrb_pkg::CFG_SAMPLE_START:
                begin
                    cfg_reg.sample_start <= cfg_data[esbrb_pkg::BYTE_W-1:0];
                end
                esbrb_pkg::CFG_PRESCALE_DIV:
                begin
                    cfg_reg.prescale_div <= cfg_data;
                end
                esbrb_pkg::CFG_HOLD_OVERFLOWS:
                begin
                    cfg_reg.hold_overflows <= cfg_data[esbrb_pkg::BYTE_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    esbrb_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .in_fire (in_fire),
        .bus     (s_tdata[0]),
        .res     (res)
    );

    // output buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= skid_valid_reg && in_fire;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (in_fire)
                begin
                    skid_reg <= res;
                end
            end
            else if (in_fire)
            begin
                out_reg <= res;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.reading, out_reg.byte_value,
                       out_reg.byte_valid, out_reg.received_led, out_reg.blink_led};

endmodule

/* rtl/esbrb_checker.sv */
module esbrb_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tready,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [esbrb_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // no byte, no value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[2]) |-> (m_tdata[10:3] == 8'h00))
        else $error("byte value set without byte_valid");

    // a completed byte always leaves read mode with the blink led dark
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (!m_tdata[11] && !m_tdata[0]))
        else $error("byte completion in wrong mode or led state");

    // the input side only stalls behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind edge_sampled_byte_receiver_blinker_unit esbrb_checker u_esbrb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/blinker_result_checker.sv */
`timescale 1ns / 100ps

module blinker_result_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [esbrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [esbrb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [esbrb_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] bus_level
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] blink_led, [1] received_led, [2] byte_valid, [10:3] byte_value,
    // [11] reading, [15:12] zero
    input  logic [esbrb_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output int                                   pending,
    output int                                   errors
);

    // register copies
    logic [esbrb_pkg::BYTE_W-1:0]     init_reload;
    logic [esbrb_pkg::BYTE_W-1:0]     samp_start;
    logic [esbrb_pkg::PRESCALE_W-1:0] pre_div;
    logic [esbrb_pkg::BYTE_W-1:0]     hold_limit;

    // receiver state
    logic                             read_mode;
    logic [esbrb_pkg::BIT_IDX_W-1:0]  bit_idx;
    logic [esbrb_pkg::BYTE_W-1:0]     shift_reg;
    logic [esbrb_pkg::BYTE_W-1:0]     period;
    logic [esbrb_pkg::PCOUNT_W-1:0]   pre_cnt;
    logic [esbrb_pkg::BYTE_W-1:0]     step_cnt;
    logic                             armed;
    logic                             blink;
    logic                             rx_led;
    logic [esbrb_pkg::BYTE_W-1:0]     hold_cnt;
    logic                             prev_bus;

    esbrb_pkg::result_t expected_ticks[$];

    task automatic flag_mismatch(input string what, input int want_v, input int got_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
    endtask

    // one base tick of the receiver, returns the outputs after the update
    function automatic esbrb_pkg::result_t next_tick_outputs(input logic bus);
        esbrb_pkg::result_t               r;
        logic [esbrb_pkg::PRESCALE_W-1:0] div;
        logic                             counter_step;
        r = '0;
        counter_step = 1'b1;

        // counter runs every tick in read mode, else on the prescaler
        if (!read_mode)
        begin
            div = pre_div;
            if (div < esbrb_pkg::PRESCALE_MIN)
                div = esbrb_pkg::PRESCALE_MIN;
            if (div > esbrb_pkg::PRESCALE_MAX)
                div = esbrb_pkg::PRESCALE_MAX;
            if ({1'b0, pre_cnt} + 11'd1 >= div)
                pre_cnt = '0;
            else
            begin
                pre_cnt = pre_cnt + 1'b1;
                counter_step = 1'b0;
            end
        end

        // overflow: sample a bit or toggle the blink led
        if (counter_step)
        begin
            if (step_cnt == esbrb_pkg::COUNT_TOP)
            begin
                step_cnt = '0;
                if (armed)
                begin
                    if (read_mode)
                    begin
                        armed = 1'b0;
                        if (bus)
                            shift_reg[bit_idx[2:0]] = 1'b1;
                        bit_idx = bit_idx + 1'b1;
                    end
                    else
                    begin
                        blink = ~blink;
                        step_cnt = period;
                        if (rx_led)
                            hold_cnt = hold_cnt + 1'b1;
                    end
                end
            end
            else
                step_cnt = step_cnt + 1'b1;
        end

        // falling edge enters read mode and arms a sample
        if (prev_bus && !bus)
        begin
            if (!read_mode)
            begin
                blink = 1'b0;
                rx_led = 1'b0;
                read_mode = 1'b1;
                pre_cnt = '0;
            end
            step_cnt = samp_start;
            armed = 1'b1;
        end
        prev_bus = bus;

        // full byte becomes the new blink period
        if (bit_idx > esbrb_pkg::LAST_BIT_IDX)
        begin
            rx_led = 1'b1;
            period = shift_reg;
            r.byte_valid = 1'b1;
            r.byte_value = shift_reg;
            shift_reg = '0;
            bit_idx = '0;
            if (read_mode)
                pre_cnt = '0;
            read_mode = 1'b0;
            step_cnt = period;
            armed = 1'b1;
        end

        // received led hold expired
        if (hold_cnt >= hold_limit)
        begin
            rx_led = 1'b0;
            hold_cnt = '0;
        end

        r.blink_led = blink;
        r.received_led = rx_led;
        r.reading = read_mode;
        return r;
    endfunction

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin : watch
        esbrb_pkg::result_t want;
        esbrb_pkg::result_t got;
        if (!rst_n)
        begin
            init_reload = esbrb_pkg::INITIAL_RELOAD_RST;
            samp_start = esbrb_pkg::SAMPLE_START_RST;
            pre_div = esbrb_pkg::PRESCALE_DIV_RST;
            hold_limit = esbrb_pkg::HOLD_OVERFLOWS_RST;
            read_mode = 1'b0;
            bit_idx = '0;
            shift_reg = '0;
            period = init_reload;
            pre_cnt = '0;
            step_cnt = init_reload;
            armed = 1'b1;
            blink = 1'b0;
            rx_led = 1'b0;
            hold_cnt = '0;
            prev_bus = 1'b1;
            errors = 0;
            expected_ticks.delete();
            pending <= 0;
        end
        else
        begin
            // compare each accepted result with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[11:0];
                if (expected_ticks.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_ticks.pop_front();
                    if (got.blink_led != want.blink_led)
                        flag_mismatch("blink_led", want.blink_led, got.blink_led);
                    if (got.received_led != want.received_led)
                        flag_mismatch("received_led", want.received_led, got.received_led);
                    if (got.byte_valid != want.byte_valid)
                        flag_mismatch("byte_valid", want.byte_valid, got.byte_valid);
                    if (got.byte_value != want.byte_value)
                        flag_mismatch("byte_value", want.byte_value, got.byte_value);
                    if (got.reading != want.reading)
                        flag_mismatch("reading", want.reading, got.reading);
                    if (m_tdata[esbrb_pkg::OUT_TDATA_W-1:12] != '0)
                        flag_mismatch("padding", 0, m_tdata[esbrb_pkg::OUT_TDATA_W-1:12]);
                end
            end

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    esbrb_pkg::CFG_INITIAL_RELOAD:
                        init_reload = cfg_data[esbrb_pkg::BYTE_W-1:0];
                    esbrb_pkg::CFG_SAMPLE_START:
                        samp_start = cfg_data[esbrb_pkg::BYTE_W-1:0];
                    esbrb_pkg::CFG_PRESCALE_DIV:
                        pre_div = cfg_data[esbrb_pkg::PRESCALE_W-1:0];
                    esbrb_pkg::CFG_HOLD_OVERFLOWS:
                        hold_limit = cfg_data[esbrb_pkg::BYTE_W-1:0];
                    default: ;
                endcase
            end

            // each accepted request is one base tick
            if (s_tvalid && s_tready)
                expected_ticks.push_back(next_tick_outputs(s_tdata[0]));

            pending <= expected_ticks.size();
        end
    end

endmodule

/* tb/edge_sampled_byte_receiver_blinker_unit_test.sv */
`timescale 1ns / 100ps

module edge_sampled_byte_receiver_blinker_unit_test;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SINK_HOLDOFF = 80;
    localparam int PHASE_TICKS  = 140;

    typedef logic [esbrb_pkg::CFG_DATA_W-1:0] cfg_word_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [esbrb_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [esbrb_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [esbrb_pkg::IN_TDATA_W-1:0]     s_tdata;   // [0] bus_level
    logic                                 m_tvalid;
    logic                                 m_tready;
    // [0] blink_led, [1] received_led, [2] byte_valid, [10:3] byte_value,
    // [11] reading, [15:12] zero
    logic [esbrb_pkg::OUT_TDATA_W-1:0]    m_tdata;
    int                                   pending;
    int                                   errors;

    // stimulus bookkeeping
    int          phase_ticks;
    int          phase_budget;
    logic [7:0]  samp_cur;
    logic        last_level;
    bit          sender_gaps;

    edge_sampled_byte_receiver_blinker_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    blinker_result_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // byte values lean toward short blink periods
    function automatic logic [7:0] random_period();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(224, 255));
    endfunction

    // one request: one base tick with the given bus level
    task automatic send_tick(input logic level);
        int gap;
        gap = sender_gaps ? random_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(esbrb_pkg::IN_TDATA_W-1){1'b0}}, level};
        do
            @(posedge clk);
        while (!s_tready);
        phase_ticks++;
        last_level = level;
    endtask

    // serial byte, lsb first: each bit is a falling edge, then the level at
    // the sample offset; stops early at the end of the phase
    task automatic send_frame(input logic [7:0] value, input int nbits);
        int lag;
        lag = 256 - samp_cur;
        for (int i = 0; i < nbits; i++)
        begin
            if (phase_ticks >= phase_budget)
                return;
            if (!last_level)
                send_tick(1'b1);
            send_tick(1'b0);
            for (int k = 1; k < lag; k++)
            begin
                if (phase_ticks >= phase_budget)
                    return;
                send_tick(1'b0);
            end
            send_tick(value[i]);
        end
    endtask

    // registers in index order on consecutive edges
    task automatic write_settings(input logic [7:0] reload, input logic [7:0] start,
                                  input logic [10:0] div, input logic [7:0] hold);
        cfg_we <= 1'b1;
        cfg_index <= esbrb_pkg::CFG_INITIAL_RELOAD;
        cfg_data <= cfg_word_t'(reload);
        @(posedge clk);
        cfg_index <= esbrb_pkg::CFG_SAMPLE_START;
        cfg_data <= cfg_word_t'(start);
        @(posedge clk);
        cfg_index <= esbrb_pkg::CFG_PRESCALE_DIV;
        cfg_data <= cfg_word_t'(div);
        @(posedge clk);
        cfg_index <= esbrb_pkg::CFG_HOLD_OVERFLOWS;
        cfg_data <= cfg_word_t'(hold);
        @(posedge clk);
        cfg_we <= 1'b0;
        samp_cur = start;
    endtask

    // stop offering and let every expected result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // stimulus
    initial
    begin : stimulus
        int pick;
        int run_len;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= esbrb_pkg::CFG_INITIAL_RELOAD;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        last_level = 1'b1;
        sender_gaps = 1'b1;
        samp_cur = esbrb_pkg::SAMPLE_START_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fastest sampling, all-ones byte, blink every tick,
        // then another falling edge while still in read mode
        write_settings(8'hFF, 8'd255, 11'd1, 8'd1);
        phase_ticks = 0;
        phase_budget = 1000;
        send_frame(8'hFF, 8);
        repeat (3) send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);

        // random phases, each under its own register setting
        for (int p = 0; p < 8; p++)
        begin
            drain();
            case (p)
                0: write_settings(8'd0, 8'd250, 11'd2, 8'd3);
                1: write_settings(8'd17, 8'd240, 11'd1, 8'd0);
                2: write_settings(8'd106, 8'd252, 11'd0, 8'd2);
                3: write_settings(8'd200, 8'd0, 11'd3, 8'd255);
                4: write_settings(8'd1, 8'd254, 11'd1024, 8'd4);
                5: write_settings(8'd90, 8'd253, 11'd2047, 8'd1);
                default: write_settings(8'($urandom_range(0, 255)),
                                        8'($urandom_range(244, 255)),
                                        11'($urandom_range(1, 4)),
                                        8'($urandom_range(1, 8)));
            endcase
            sender_gaps = ($urandom_range(0, 3) != 0);
            phase_ticks = 0;
            phase_budget = PHASE_TICKS;
            while (phase_ticks < phase_budget)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    send_frame(random_period(), 8);
                else if (pick == 6)
                    send_frame(8'($urandom_range(0, 255)), $urandom_range(1, 7));
                else if (pick < 9)
                begin
                    // bus idles high
                    run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                          : $urandom_range(1, 20);
                    for (int k = 0; k < run_len && phase_ticks < phase_budget; k++)
                        send_tick(1'b1);
                end
                else
                begin
                    // random bus noise
                    run_len = $urandom_range(1, 16);
                    for (int k = 0; k < run_len && phase_ticks < phase_budget; k++)
                        send_tick(1'($urandom_range(0, 1)));
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[edge_sampled_byte_receiver_blinker_unit] OK");
        else
            $display("[edge_sampled_byte_receiver_blinker_unit] ERROR");
        $finish;
    end

    // result side: random stalls, steady stretches, one long hold-off
    initial
    begin : result_sink
        int  taken;
        int  stall_left;
        int  stretch_left;
        bit  steady;
        bit  held;
        taken = 0;
        stall_left = 0;
        stretch_left = $urandom_range(50, 200);
        steady = 1'b0;
        held = 1'b0;
        m_tready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                taken++;
            if (stall_left > 0)
                stall_left--;
            else if (!held && taken >= 200)
            begin
                held = 1'b1;
                stall_left = SINK_HOLDOFF;
            end
            else if (!steady)
                stall_left = random_gap();
            stretch_left--;
            if (stretch_left <= 0)
            begin
                steady = !steady;
                stretch_left = $urandom_range(50, 200);
            end
            m_tready <= (stall_left == 0);
        end
    end

    // watchdog on cycles with no request or result accepted
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
                quiet++;
            else
                quiet = 0;
        end
        $display("[edge_sampled_byte_receiver_blinker_unit] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/esbrb_pkg.sv
rtl/esbrb_core.sv
rtl/edge_sampled_byte_receiver_blinker_unit.sv
rtl/esbrb_checker.sv
tb/blinker_result_checker.sv
tb/edge_sampled_byte_receiver_blinker_unit_test.sv
